// ===== sv/pipr_pkg.sv =====
// Shared types and constants for the point-in-polygon ray-cast core.
// Holds op codes, coordinate widths and the controller/datapath structs.
// No dependencies.
package pipr_pkg;

	localparam int LAT_W = 31;
	localparam int LON_W = 32;
	localparam int VC_W = 9;
	localparam int OP_W = 2;
	localparam int PROD_W = LAT_W + LON_W + 2;
	localparam int MIN_POLY_VERTICES = 3;

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_TEST = 2'd2;

	typedef struct packed {
		logic accept;
		logic clear;
		logic append;
		logic walk_init;
		logic rd;
	} pipr_cmd_t;

	typedef struct packed {
		logic full;
		logic few;
		logic rd_last;
		logic pipe_busy;
	} pipr_sts_t;

endpackage

// ===== sv/pipr_dp.sv =====
// Datapath of the point-in-polygon ray-cast core: vertex store, count,
// edge walk pointer and the three-stage edge crossing pipeline.
// Depends on pipr_pkg.
module pipr_dp #(
	parameter int MAX_VERTICES = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pipr_pkg::pipr_cmd_t                  cmd,
	input  logic signed [pipr_pkg::LAT_W-1:0]    lat,
	input  logic signed [pipr_pkg::LON_W-1:0]    lon,
	output pipr_pkg::pipr_sts_t                  sts,
	output logic                                 inside_res,
	output logic                                 status,
	output logic [pipr_pkg::VC_W-1:0]            vertex_count
);

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int EW = pipr_pkg::LAT_W + pipr_pkg::LON_W;

	logic [EW-1:0] mem [MAX_VERTICES];

	logic [CW-1:0] count_q;
	logic [AW-1:0] rd_ptr_q;
	logic          first_q;
	logic [AW-1:0] cnt_m1;
	logic [CW-1:0] cnt_dec;

	logic signed [pipr_pkg::LAT_W-1:0] pt_lat_q;
	logic signed [pipr_pkg::LON_W-1:0] pt_lon_q;

	logic [EW-1:0] rd_data_s0;
	logic          rd_vld_s0;
	logic          rd_first_s0;
	logic signed [pipr_pkg::LAT_W-1:0] cur_lat;
	logic signed [pipr_pkg::LON_W-1:0] cur_lon;
	logic signed [pipr_pkg::LAT_W-1:0] prev_lat_q;
	logic signed [pipr_pkg::LON_W-1:0] prev_lon_q;

	logic                               vld_s1;
	logic                               cross_s1;
	logic signed [pipr_pkg::LAT_W:0]    dy_s1;
	logic signed [pipr_pkg::LAT_W:0]    dlat_s1;
	logic signed [pipr_pkg::LON_W:0]    dlon_s1;
	logic signed [pipr_pkg::LON_W:0]    dx_s1;

	logic                               vld_s2;
	logic                               cross_s2;
	logic                               neg_s2;
	logic signed [pipr_pkg::PROD_W-1:0] lhs_s2;
	logic signed [pipr_pkg::PROD_W-1:0] rhs_s2;
	logic                               below;

	logic inside_q;
	logic status_q;

	assign cnt_dec = count_q - CW'(1);
	assign cnt_m1 = cnt_dec[AW-1:0];
	assign cur_lat = rd_data_s0[pipr_pkg::LON_W +: pipr_pkg::LAT_W];
	assign cur_lon = rd_data_s0[pipr_pkg::LON_W-1:0];

	assign sts.full = (count_q == CW'(MAX_VERTICES));
	assign sts.few = (count_q < CW'(pipr_pkg::MIN_POLY_VERTICES));
	assign sts.rd_last = !first_q && (rd_ptr_q == cnt_m1);
	assign sts.pipe_busy = rd_vld_s0 | vld_s1 | vld_s2;

	always_ff @(posedge clk) begin
		if (cmd.accept && cmd.append && !sts.full) begin
			mem[count_q[AW-1:0]] <= {lat, lon};
		end
		if (cmd.rd) begin
			rd_data_s0 <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			status_q <= 1'b0;
		end else if (cmd.accept) begin
			status_q <= cmd.append && sts.full;
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.append && !sts.full) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			first_q <= 1'b0;
			rd_vld_s0 <= 1'b0;
			rd_first_s0 <= 1'b0;
		end else begin
			rd_vld_s0 <= cmd.rd;
			rd_first_s0 <= first_q;
			if (cmd.walk_init) begin
				rd_ptr_q <= cnt_m1;
				first_q <= 1'b1;
			end else if (cmd.rd) begin
				first_q <= 1'b0;
				rd_ptr_q <= first_q ? '0 : rd_ptr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			pt_lat_q <= lat;
			pt_lon_q <= lon;
		end
		if (rd_vld_s0) begin
			prev_lat_q <= cur_lat;
			prev_lon_q <= cur_lon;
		end
		cross_s1 <= (cur_lon > pt_lon_q) != (prev_lon_q > pt_lon_q);
		dlon_s1 <= prev_lon_q - cur_lon;
		dlat_s1 <= prev_lat_q - cur_lat;
		dx_s1 <= pt_lon_q - cur_lon;
		dy_s1 <= pt_lat_q - cur_lat;
		lhs_s2 <= dy_s1 * dlon_s1;
		rhs_s2 <= dlat_s1 * dx_s1;
		neg_s2 <= dlon_s1[pipr_pkg::LON_W];
		cross_s2 <= cross_s1;
	end

	assign below = neg_s2 ? (rhs_s2 < lhs_s2) : (lhs_s2 < rhs_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			inside_q <= 1'b0;
		end else begin
			vld_s1 <= rd_vld_s0 && !rd_first_s0;
			vld_s2 <= vld_s1;
			if (cmd.accept) begin
				inside_q <= 1'b0;
			end else if (vld_s2 && cross_s2 && below) begin
				inside_q <= !inside_q;
			end
		end
	end

	assign inside_res = inside_q;
	assign status = status_q;
	assign vertex_count = pipr_pkg::VC_W'(count_q);

endmodule

// ===== sv/pipr_ctrl.sv =====
// Controller of the point-in-polygon ray-cast core: decodes the op,
// sequences the edge walk, waits for the pipeline and strobes the result.
// Depends on pipr_pkg.
module pipr_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pipr_pkg::OP_W-1:0] op,
	input  pipr_pkg::pipr_sts_t       sts,
	output pipr_pkg::pipr_cmd_t       cmd,
	output logic                      busy,
	output logic                      done
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_RESP = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d = ST_RESP;
					unique case (op)
						pipr_pkg::OP_CLEAR: begin
							cmd.clear = 1'b1;
						end
						pipr_pkg::OP_APPEND: begin
							cmd.append = 1'b1;
						end
						pipr_pkg::OP_TEST: begin
							if (!sts.few) begin
								cmd.walk_init = 1'b1;
								state_d = ST_WALK;
							end
						end
						default: begin
							state_d = ST_RESP;
						end
					endcase
				end
			end
			ST_WALK: begin
				cmd.rd = 1'b1;
				if (sts.rd_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_RESP);

endmodule

// ===== sv/point_in_polygon_ray_cast_core.sv =====
// Point-in-polygon ray-cast core. A transfer is taken when start is high and
// busy is low; each transfer yields exactly one result, shown for one cycle
// with done high, which the receiver must take as it comes. Clear, append and
// unused ops go straight to the result. A test of a polygon with n >= 3
// vertices walks the edges: the single read port of the vertex store makes
// n + 1 reads, one edge per cycle, then a three-stage compare pipeline drains.
// A test with fewer than 3 vertices skips the walk and reports outside.
// Depends on pipr_pkg, pipr_ctrl, pipr_dp.
module point_in_polygon_ray_cast_core #(
	parameter int MAX_VERTICES = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [pipr_pkg::OP_W-1:0]         op,
	input  logic signed [pipr_pkg::LAT_W-1:0] lat,
	input  logic signed [pipr_pkg::LON_W-1:0] lon,
	output logic                              done,
	output logic                              inside_res,
	output logic                              status,
	output logic [pipr_pkg::VC_W-1:0]         vertex_count
);

	pipr_pkg::pipr_cmd_t cmd;
	pipr_pkg::pipr_sts_t sts;

	pipr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	pipr_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.lat          (lat),
		.lon          (lon),
		.sts          (sts),
		.inside_res   (inside_res),
		.status       (status),
		.vertex_count (vertex_count)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transfer did not raise busy");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("result strobe not followed by idle");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(inside_res && status))
		else $error("inside and store-full flags both set");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(MAX_VERTICES > 511) || (vertex_count <= pipr_pkg::VC_W'(MAX_VERTICES)))
		else $error("vertex count above store depth");

endmodule

// ===== bench/point_in_polygon_ray_cast_core_tb.sv =====
// Self-checking testbench for point_in_polygon_ray_cast_core: directed table, then random
// polygon build/test runs, results checked vs table rows or an exact ray-cast predictor.
// Depends on pipr_pkg and the core RTL.
module point_in_polygon_ray_cast_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LAT_W = pipr_pkg::LAT_W;
	localparam int LON_W = pipr_pkg::LON_W;
	localparam int VC_W = pipr_pkg::VC_W;
	localparam int OP_W = pipr_pkg::OP_W;
	localparam int MIN_POLY_VERTICES = pipr_pkg::MIN_POLY_VERTICES;
	localparam logic [OP_W-1:0] OP_CLEAR = pipr_pkg::OP_CLEAR;
	localparam logic [OP_W-1:0] OP_APPEND = pipr_pkg::OP_APPEND;
	localparam logic [OP_W-1:0] OP_TEST = pipr_pkg::OP_TEST;

	localparam int MAX_VERTICES = 256;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic ins;
		logic st;
		logic [VC_W-1:0] cnt;
	} answer_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [LAT_W-1:0] lat;
		logic [LON_W-1:0] lon;
		logic typed;
		logic ins;
		logic st;
		logic [VC_W-1:0] cnt;
	} dir_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [OP_W-1:0] op = '0;
	logic signed [LAT_W-1:0] lat = '0;
	logic signed [LON_W-1:0] lon = '0;
	logic done;
	logic inside_res;
	logic status;
	logic [VC_W-1:0] vertex_count;

	logic signed [LAT_W-1:0] poly_lat [MAX_VERTICES];
	logic signed [LON_W-1:0] poly_lon [MAX_VERTICES];
	int poly_n = 0;

	answer_t expected_answers [$];
	answer_t want;
	int idle_pct = 0;
	int mismatches = 0;
	int answers_checked = 0;
	int items_sent = 0;
	int tests_sent = 0;
	int tests_inside = 0;
	int appends_sent = 0;
	int appends_dropped = 0;
	int fills = 0;

	dir_row_t dir_rows [23] = '{
		'{OP_TEST, 31'sd0, 32'sd0, 1'b1, 1'b0, 1'b0, 9'd0},
		'{OP_UNUSED, 31'sd0, 32'sd0, 1'b1, 1'b0, 1'b0, 9'd0},
		'{OP_APPEND, -31'sd900000000, -32'sd1800000000, 1'b1, 1'b0, 1'b0, 9'd1},
		'{OP_APPEND, 31'sd900000000, -32'sd1800000000, 1'b1, 1'b0, 1'b0, 9'd2},
		'{OP_TEST, 31'sd0, 32'sd0, 1'b1, 1'b0, 1'b0, 9'd2},
		'{OP_APPEND, 31'sd900000000, 32'sd1800000000, 1'b1, 1'b0, 1'b0, 9'd3},
		'{OP_APPEND, -31'sd900000000, 32'sd1800000000, 1'b1, 1'b0, 1'b0, 9'd4},
		'{OP_TEST, 31'sd0, 32'sd0, 1'b0, 1'b0, 1'b0, 9'd0},
		'{OP_TEST, 31'sd900000000, 32'sd1800000000, 1'b0, 1'b0, 1'b0, 9'd0},
		'{OP_TEST, -31'sd900000000, -32'sd1800000000, 1'b0, 1'b0, 1'b0, 9'd0},
		'{OP_TEST, 31'h3fffffff, 32'h7fffffff, 1'b0, 1'b0, 1'b0, 9'd0},
		'{OP_TEST, 31'h40000000, 32'h80000000, 1'b0, 1'b0, 1'b0, 9'd0},
		'{OP_TEST, 31'sd0, 32'sd1800000000, 1'b0, 1'b0, 1'b0, 9'd0},
		'{OP_UNUSED, 31'h7fffffff, 32'hffffffff, 1'b1, 1'b0, 1'b0, 9'd4},
		'{OP_CLEAR, 31'h7fffffff, 32'hffffffff, 1'b1, 1'b0, 1'b0, 9'd0},
		'{OP_APPEND, 31'h40000000, 32'h80000000, 1'b1, 1'b0, 1'b0, 9'd1},
		'{OP_APPEND, 31'h3fffffff, 32'sd0, 1'b1, 1'b0, 1'b0, 9'd2},
		'{OP_APPEND, 31'sd0, 32'h7fffffff, 1'b1, 1'b0, 1'b0, 9'd3},
		'{OP_TEST, 31'sd0, 32'sd0, 1'b0, 1'b0, 1'b0, 9'd0},
		'{OP_TEST, -31'sd5, 32'sd100, 1'b0, 1'b0, 1'b0, 9'd0},
		'{OP_TEST, 31'h40000000, 32'h7ffffffe, 1'b0, 1'b0, 1'b0, 9'd0},
		'{OP_CLEAR, 31'sd0, 32'sd0, 1'b1, 1'b0, 1'b0, 9'd0},
		'{OP_UNUSED, 31'h40000000, 32'h80000000, 1'b1, 1'b0, 1'b0, 9'd0}
	};

	point_in_polygon_ray_cast_core #(
		.MAX_VERTICES(MAX_VERTICES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.lat(lat),
		.lon(lon),
		.done(done),
		.inside_res(inside_res),
		.status(status),
		.vertex_count(vertex_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit point_in_stored_polygon(logic signed [LAT_W-1:0] plat,
			logic signed [LON_W-1:0] plon);
		logic signed [127:0] ilat, ilon, jlat, jlon, px, py, dlon, dlat, lhs, rhs;
		int i;
		int j;
		bit odd_crossings;
		odd_crossings = 1'b0;
		if (poly_n < MIN_POLY_VERTICES)
			return 1'b0;
		px = plon;
		py = plat;
		j = poly_n - 1;
		for (i = 0; i < poly_n; i++) begin
			ilat = poly_lat[i];
			ilon = poly_lon[i];
			jlat = poly_lat[j];
			jlon = poly_lon[j];
			if ((ilon > px) != (jlon > px)) begin
				dlon = jlon - ilon;
				dlat = jlat - ilat;
				lhs = (py - ilat) * dlon;
				rhs = dlat * (px - ilon);
				if (dlon > 0 ? lhs < rhs : rhs < lhs)
					odd_crossings = ~odd_crossings;
			end
			j = i;
		end
		return odd_crossings;
	endfunction

	function automatic answer_t ray_cast_step(logic [OP_W-1:0] o, logic signed [LAT_W-1:0] la,
			logic signed [LON_W-1:0] lo);
		answer_t a;
		a = '0;
		case (o)
			OP_CLEAR: poly_n = 0;
			OP_APPEND: begin
				appends_sent++;
				if (poly_n < MAX_VERTICES) begin
					poly_lat[poly_n] = la;
					poly_lon[poly_n] = lo;
					poly_n++;
				end else begin
					a.st = 1'b1;
					appends_dropped++;
				end
			end
			OP_TEST: begin
				a.ins = point_in_stored_polygon(la, lo);
				tests_sent++;
				tests_inside += a.ins;
			end
			default: ;
		endcase
		a.cnt = VC_W'(poly_n);
		return a;
	endfunction

	function automatic void enqueue_answer(answer_t x);
		expected_answers = {expected_answers, x};
	endfunction

	task automatic send_item(input logic [OP_W-1:0] o, input logic signed [LAT_W-1:0] la,
			input logic signed [LON_W-1:0] lo, input bit typed = 1'b0,
			input answer_t typed_ans = '0);
		answer_t a;
		op <= o;
		lat <= la;
		lon <= lo;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		a = ray_cast_step(o, la, lo);
		enqueue_answer(typed ? typed_ans : a);
		items_sent++;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic await_all_answers();
		start <= 1'b0;
		while (expected_answers.size() != 0)
			@(posedge clk);
	endtask

	// how: 0 near center, 1 any bit pattern, 2 a stored vertex, 3 stored longitude
	task automatic pick_coord(input int how, input int c_lat, input longint c_lon,
			input int span, output logic signed [LAT_W-1:0] la,
			output logic signed [LON_W-1:0] lo);
		int v;
		v = (poly_n > 0) ? $urandom_range(0, poly_n - 1) : 0;
		la = LAT_W'(c_lat + int'($urandom_range(0, 2 * span)) - span);
		lo = LON_W'(c_lon + longint'($urandom_range(0, 2 * span)) - span);
		if (how == 1) begin
			la = LAT_W'($urandom);
			lo = $urandom;
		end else if (how == 2 && poly_n > 0) begin
			la = poly_lat[v];
			lo = poly_lon[v];
		end else if (how == 3 && poly_n > 0) begin
			lo = poly_lon[v];
		end
	endtask

	task automatic run_phase(input int pct, input int quota);
		int target;
		int kind;
		int r;
		int nv;
		int nt;
		int k;
		int c_lat;
		longint c_lon;
		int span;
		bit raw;
		logic signed [LAT_W-1:0] la;
		logic signed [LON_W-1:0] lo;
		idle_pct = pct;
		target = items_sent + quota;
		while (items_sent < target) begin
			kind = $urandom_range(99);
			raw = ($urandom_range(99) < 25);
			c_lat = int'($urandom_range(0, 1800000000)) - 900000000;
			c_lon = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
			case ($urandom_range(3))
				0: span = 10;
				1: span = 1000;
				2: span = 100000;
				default: span = 10000000;
			endcase
			if (kind < 75) begin
				send_item(OP_CLEAR, LAT_W'($urandom), $urandom);
				r = $urandom_range(99);
				if ((fills == 0 && pct == 58) || (fills < 2 && r < 2)) begin
					nv = MAX_VERTICES + $urandom_range(1, 3);
					fills++;
				end else if (r < 12) begin
					nv = $urandom_range(0, 2);
				end else if (r < 17) begin
					nv = $urandom_range(11, 40);
				end else begin
					nv = $urandom_range(3, 10);
				end
				for (k = 0; k < nv; k++) begin
					pick_coord(raw ? 1 : 0, c_lat, c_lon, span, la, lo);
					send_item(OP_APPEND, la, lo);
				end
				nt = (nv > 40) ? $urandom_range(1, 2) : $urandom_range(2, 8);
				for (k = 0; k < nt; k++) begin
					r = $urandom_range(9);
					pick_coord(r == 9 ? 1 : (r >= 7 ? 3 : (r >= 5 ? 2 : (raw ? 1 : 0))),
						c_lat, c_lon, span, la, lo);
					send_item(OP_TEST, la, lo);
				end
			end else if (kind < 90) begin
				send_item(OP_W'($urandom), LAT_W'($urandom), $urandom);
			end else begin
				// extend whatever polygon is stored, no clear first
				nv = $urandom_range(1, 3);
				for (k = 0; k < nv; k++) begin
					pick_coord(raw ? 1 : 0, c_lat, c_lon, span, la, lo);
					send_item(OP_APPEND, la, lo);
				end
				pick_coord($urandom_range(0, 3), c_lat, c_lon, span, la, lo);
				send_item(OP_TEST, la, lo);
			end
		end
		await_all_answers();
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				$error("result with no transfer pending");
				mismatches++;
			end else begin
				want = expected_answers.pop_front();
				if (inside_res !== want.ins) begin
					$error("inside_res: expected %0d, got %0d", want.ins, inside_res);
					mismatches++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					mismatches++;
				end
				if (vertex_count !== want.cnt) begin
					$error("vertex_count: expected %0d, got %0d", want.cnt, vertex_count);
					mismatches++;
				end
				answers_checked++;
			end
		end
	end

	initial begin
		int k;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 10;
		for (k = 0; k < 23; k++)
			send_item(dir_rows[k].op, dir_rows[k].lat, dir_rows[k].lon, dir_rows[k].typed,
				'{dir_rows[k].ins, dir_rows[k].st, dir_rows[k].cnt});
		await_all_answers();
		run_phase(10, 590);
		run_phase(58, 590);
		run_phase(0, 590);
		repeat (MAX_VERTICES + 16) @(posedge clk);
		$display("%0d transfers, %0d results checked, %0d full-store fills", items_sent,
			answers_checked, fills);
		$display("%0d point tests (%0d inside), %0d appends (%0d dropped)", tests_sent,
			tests_inside, appends_sent, appends_dropped);
		if (mismatches == 0)
			$display("point_in_polygon_ray_cast_core_tb OK");
		else
			$display("point_in_polygon_ray_cast_core_tb NOT OK");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("point_in_polygon_ray_cast_core_tb NOT OK");
		$finish;
	end

endmodule
